// ===== rtl/sv32_ptw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv32_ptw_pkg
// Types and constants shared by the Sv32 page table walker files.
// ----------------------------------------------------------------------------
package sv32_ptw_pkg;

   localparam int PageOffsetBits = 12;
   localparam int AddrBits       = 34;
   localparam int CsrAddrBits    = 4;

   // result kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_FAULT = 2'd3;

   // fault kinds
   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_PAGE   = 2'd1;
   localparam logic [1:0] FAULT_ACCESS = 2'd2;

   // access kinds
   localparam logic [1:0] ACC_LOAD  = 2'd0;
   localparam logic [1:0] ACC_STORE = 2'd1;
   localparam logic [1:0] ACC_FETCH = 2'd2;
   localparam logic [1:0] ACC_BAD   = 2'd3;

   // privilege
   localparam logic [1:0] PRIV_USER    = 2'd0;
   localparam logic [1:0] PRIV_SUPER   = 2'd1;
   localparam logic [1:0] PRIV_RSVD    = 2'd2;
   localparam logic [1:0] PRIV_MACHINE = 2'd3;

   // request actions
   localparam logic ACT_TRANSLATE = 1'b0;
   localparam logic ACT_RESPONSE  = 1'b1;

   // register indexes
   localparam logic [1:0] REG_TRANSLATION_ON = 2'd0;
   localparam logic [1:0] REG_ROOT_PAGE      = 2'd1;
   localparam logic [1:0] REG_SUM            = 2'd2;
   localparam logic [1:0] REG_MXR            = 2'd3;

   // entry bit positions
   localparam int PTE_V = 0;
   localparam int PTE_R = 1;
   localparam int PTE_W = 2;
   localparam int PTE_X = 3;
   localparam int PTE_U = 4;
   localparam int PTE_A = 6;
   localparam int PTE_D = 7;

   typedef struct packed {
      logic                action;
      logic [31:0]         virt_addr;
      logic [1:0]          access_kind;
      logic [1:0]          eff_priv;
      logic [31:0]         entry_word;
      logic                entry_read_allowed;
      logic                entry_write_allowed;
   } req_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [AddrBits-1:0] address;
      logic [31:0]         write_word;
      logic [1:0]          fault_kind;
      logic                last_result;
   } rsp_type;

endpackage

// ===== rtl/sv32_ptw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv32_ptw_if
// Valid/ready channels of the page table walker: request and result.
// ----------------------------------------------------------------------------
interface sv32_ptw_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] virt_addr;
   logic [1:0]  access_kind;
   logic [1:0]  eff_priv;
   logic [31:0] entry_word;
   logic        entry_read_allowed;
   logic        entry_write_allowed;

   modport source (
      output valid, action, virt_addr, access_kind, eff_priv,
             entry_word, entry_read_allowed, entry_write_allowed,
      input  ready
   );
   modport sink (
      input  valid, action, virt_addr, access_kind, eff_priv,
             entry_word, entry_read_allowed, entry_write_allowed,
      output ready
   );
endinterface

interface sv32_ptw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [33:0] address;
   logic [31:0] write_word;
   logic [1:0]  fault_kind;
   logic        last_result;

   modport source (
      output valid, result_kind, address, write_word, fault_kind, last_result,
      input  ready
   );
   modport sink (
      input  valid, result_kind, address, write_word, fault_kind, last_result,
      output ready
   );
endinterface

// ===== rtl/sv32_page_table_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv32_page_table_walker
// Two-level Sv32 walker: request register, one-pass check, two-entry result
// buffer.
// ----------------------------------------------------------------------------
// Flow: the request is registered, and its results then enter the result buffer.
// Throughput: 1 transaction per cycle while each produces at most one result
// and the result buffer has a free slot; a transaction with two results (A/D
// write plus completion or fault) waits for an empty result buffer.
// Reset: synchronous; clears CSRs and walk state, empties both buffers.
module sv32_page_table_walker #(
   parameter int PHYS_ADDR_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   sv32_ptw_req_if.sink                          req_chan,
   sv32_ptw_rsp_if.source                        rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sv32_ptw_pkg::CsrAddrBits-1:0]  paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import sv32_ptw_pkg::*;

   localparam logic [AddrBits-1:0] PhysMask =
      AddrBits'((35'd1 << PHYS_ADDR_BITS) - 35'd1);

   // CSRs
   logic        trans_on_ff;
   logic [21:0] root_ppn_ff;
   logic        sum_ff;
   logic        mxr_ff;
   logic        csr_wr;

   // input register
   logic        req_valid_ff;
   req_type     req_ff;
   logic        req_take;
   logic        fire;

   // walk state
   logic                busy_ff,   busy_in;
   logic                level_ff,  level_in;
   logic [31:0]         va_ff,     va_in;
   logic [1:0]          kind_ff,   kind_in;
   logic [1:0]          priv_ff,   priv_in;
   logic [AddrBits-1:0] pend_ff,   pend_in;

   // result buffer
   rsp_type     buf_ff [2];
   logic        rd_ptr_ff;
   logic        wr_ptr_ff;
   logic [1:0]  count_ff;
   logic        pop;
   logic [1:0]  free_slots;

   // single-pass evaluation
   rsp_type             res0, res1;
   logic [1:0]          n_res;
   logic [21:0]         ppn;
   logic [31:0]         pte;
   logic [AddrBits-1:0] ent_addr;
   logic [AddrBits-1:0] pa;
   logic [7:0]          need;
   logic                perm_ok;
   logic                allow;
   logic                is_leaf;
   logic                new_kind_store;

   // ---------------------------------------------------------------- CSR port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_on_ff <= 1'b0;
         root_ppn_ff <= '0;
         sum_ff      <= 1'b0;
         mxr_ff      <= 1'b0;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_TRANSLATION_ON: trans_on_ff <= pwdata[0];
            REG_ROOT_PAGE:      root_ppn_ff <= pwdata[21:0];
            REG_SUM:            sum_ff      <= pwdata[0];
            REG_MXR:            mxr_ff      <= pwdata[0];
            default:            trans_on_ff <= trans_on_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TRANSLATION_ON: prdata = {31'd0, trans_on_ff};
         REG_ROOT_PAGE:      prdata = {10'd0, root_ppn_ff};
         REG_SUM:            prdata = {31'd0, sum_ff};
         REG_MXR:            prdata = {31'd0, mxr_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- input register
   assign req_chan.ready = ~req_valid_ff | fire;
   assign req_take       = req_chan.valid & req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_take | (req_valid_ff & ~fire);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.action              <= req_chan.action;
         req_ff.virt_addr           <= req_chan.virt_addr;
         req_ff.access_kind         <= req_chan.access_kind;
         req_ff.eff_priv            <= req_chan.eff_priv;
         req_ff.entry_word          <= req_chan.entry_word;
         req_ff.entry_read_allowed  <= req_chan.entry_read_allowed;
         req_ff.entry_write_allowed <= req_chan.entry_write_allowed;
      end
   end

   // ------------------------------------------------------------- walk logic
   assign pte            = req_ff.entry_word;
   assign ppn            = pte[31:10];
   assign is_leaf        = pte[PTE_R] | pte[PTE_X];
   assign new_kind_store = (kind_ff == ACC_STORE);
   assign need           = {new_kind_store, 7'h40};
   assign ent_addr       = {ppn, va_ff[21:12], 2'b00};
   assign pa = level_ff ? {ppn[21:10], va_ff[21:0]} : {ppn, va_ff[11:0]};

   always_comb begin
      case (kind_ff)
         ACC_FETCH: perm_ok = pte[PTE_X];
         ACC_STORE: perm_ok = pte[PTE_W];
         default:   perm_ok = pte[PTE_R] | (mxr_ff & pte[PTE_X]);
      endcase
      if (priv_ff == PRIV_USER) begin
         allow = perm_ok & pte[PTE_U];
      end else if (pte[PTE_U]) begin
         allow = perm_ok & (kind_ff != ACC_FETCH) & sum_ff;
      end else begin
         allow = perm_ok;
      end
   end

   always_comb begin
      res0     = '0;
      res1     = '0;
      n_res    = 2'd0;
      busy_in  = busy_ff;
      level_in = level_ff;
      va_in    = va_ff;
      kind_in  = kind_ff;
      priv_in  = priv_ff;
      pend_in  = pend_ff;

      res0.last_result = 1'b1;
      res1.last_result = 1'b1;

      if (req_ff.action == ACT_TRANSLATE) begin
         busy_in  = 1'b0;
         level_in = 1'b1;
         n_res    = 2'd1;
         if (req_ff.eff_priv == PRIV_MACHINE || !trans_on_ff) begin
            res0.result_kind = KIND_DONE;
            res0.address     = {2'b00, req_ff.virt_addr};
         end else begin
            va_in   = req_ff.virt_addr;
            kind_in = (req_ff.access_kind == ACC_BAD) ? ACC_LOAD
                                                      : req_ff.access_kind;
            priv_in = (req_ff.eff_priv == PRIV_RSVD) ? PRIV_SUPER
                                                     : req_ff.eff_priv;
            res0.address = {root_ppn_ff, req_ff.virt_addr[31:22], 2'b00};
            if (res0.address > PhysMask) begin
               res0.result_kind = KIND_FAULT;
               res0.fault_kind  = FAULT_ACCESS;
               res0.address     = '0;
            end else begin
               res0.result_kind = KIND_READ;
               pend_in          = res0.address;
               busy_in          = 1'b1;
            end
         end
      end else if (busy_ff) begin
         n_res            = 2'd1;
         res0.result_kind = KIND_FAULT;
         busy_in          = 1'b0;
         level_in         = 1'b1;
         if (!req_ff.entry_read_allowed) begin
            res0.fault_kind = FAULT_ACCESS;
         end else if (!pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W])) begin
            res0.fault_kind = FAULT_PAGE;
         end else if (is_leaf) begin
            if ((level_ff && ppn[9:0] != 10'd0) || !allow) begin
               res0.fault_kind = FAULT_PAGE;
            end else if ((pte[7:0] & need) != need && !req_ff.entry_write_allowed) begin
               res0.fault_kind = FAULT_ACCESS;
            end else if ((pte[7:0] & need) != need) begin
               n_res            = 2'd2;
               res0.result_kind = KIND_WRITE;
               res0.address     = pend_ff;
               res0.write_word  = pte | {24'd0, need};
               res0.last_result = 1'b0;
               if (pa > PhysMask) begin
                  res1.result_kind = KIND_FAULT;
                  res1.fault_kind  = FAULT_ACCESS;
               end else begin
                  res1.result_kind = KIND_DONE;
                  res1.address     = pa;
               end
            end else if (pa > PhysMask) begin
               res0.fault_kind = FAULT_ACCESS;
            end else begin
               res0.result_kind = KIND_DONE;
               res0.address     = pa;
            end
         end else if (pte[PTE_A] || pte[PTE_D] || pte[PTE_U] || !level_ff) begin
            res0.fault_kind = FAULT_PAGE;
         end else if (ent_addr > PhysMask) begin
            res0.fault_kind = FAULT_ACCESS;
         end else begin
            res0.result_kind = KIND_READ;
            res0.address     = ent_addr;
            pend_in          = ent_addr;
            busy_in          = 1'b1;
            level_in         = 1'b0;
         end
      end
   end

   assign free_slots = 2'd2 - count_ff;
   assign fire       = req_valid_ff & (n_res <= free_slots);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         level_ff <= 1'b1;
         va_ff    <= '0;
         kind_ff  <= ACC_LOAD;
         priv_ff  <= PRIV_USER;
         pend_ff  <= '0;
      end else if (fire) begin
         busy_ff  <= busy_in;
         level_ff <= level_in;
         va_ff    <= va_in;
         kind_ff  <= kind_in;
         priv_ff  <= priv_in;
         pend_ff  <= pend_in;
      end
   end

   // ----------------------------------------------------------- result buffer
   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign pop                  = rsp_chan.valid & rsp_chan.ready;
   assign rsp_chan.result_kind = buf_ff[rd_ptr_ff].result_kind;
   assign rsp_chan.address     = buf_ff[rd_ptr_ff].address;
   assign rsp_chan.write_word  = buf_ff[rd_ptr_ff].write_word;
   assign rsp_chan.fault_kind  = buf_ff[rd_ptr_ff].fault_kind;
   assign rsp_chan.last_result = buf_ff[rd_ptr_ff].last_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_ff ^ pop;
         wr_ptr_ff <= fire ? (wr_ptr_ff ^ n_res[0]) : wr_ptr_ff;
         count_ff  <= count_ff + (fire ? n_res : 2'd0) - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (fire && n_res != 2'd0) begin
         buf_ff[wr_ptr_ff] <= res0;
      end
      if (fire && n_res == 2'd2) begin
         buf_ff[~wr_ptr_ff] <= res1;
      end
   end

   // -------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overfilled");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      fire && n_res == 2'd2 |-> res0.result_kind == KIND_WRITE && !res0.last_result)
      else $error("two-result transaction must lead with entry write");

   a_fault_ends_walk: assert property (@(posedge clock) disable iff (reset)
      fire && n_res != 2'd0 && res0.result_kind == KIND_FAULT |=> !busy_ff && level_ff)
      else $error("walk still active after fault");

   a_read_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      fire && n_res == 2'd1 && res0.result_kind == KIND_READ |=> busy_ff)
      else $error("entry read issued without an active walk");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Sv32 page table walker against its own walk predictor.
// Directed walks first, then random walks, most phases under random idle bursts.
// The CSRs are rewritten between phases and read back.
// Each result transaction is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
   import sv32_ptw_pkg::*;

   localparam int          PhysBits  = 32;
   localparam logic [63:0] PhysLimit = (64'd1 << PhysBits) - 1;
   localparam int          MaxCycles = 400000;

   typedef struct packed {
      logic        xlate_on;
      logic [21:0] root_page;
      logic        sum;
      logic        mxr;
   } cfg_type;

   typedef struct {
      logic    set_cfg;
      cfg_type cfg;
      req_type item;
      logic    typed;
      rsp_type result;
   } step_row_type;

   logic                   clock;
   logic                   reset;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CsrAddrBits-1:0] paddr;
   logic [31:0]            pwdata;
   logic [31:0]            prdata;
   logic                   pready;

   sv32_ptw_req_if req_chan ();
   sv32_ptw_rsp_if rsp_chan ();

   sv32_page_table_walker #(.PHYS_ADDR_BITS(PhysBits)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // walk predictor state
   cfg_type     cfg;
   logic        walking;
   logic        root_level;
   logic [31:0] walk_va;
   logic [1:0]  walk_kind;
   logic [1:0]  walk_priv;
   logic [63:0] entry_addr;

   rsp_type      pending_results[$];
   step_row_type plan_q[$];
   int           mismatches;
   int           cycles;
   int           stall_left;
   logic         bursts_on;
   logic         typed_on;
   rsp_type      typed_result;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic string describe_result(rsp_type r);
      return $sformatf("kind %0d addr %h word %h fault %0d last %0d", r.result_kind,
                       r.address, r.write_word, r.fault_kind, r.last_result);
   endfunction

   task automatic flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   function automatic void push_result(logic [1:0] kind, logic [63:0] addr, logic [31:0] word,
                                       logic [1:0] fault, logic last);
      rsp_type r;
      r.result_kind = kind;
      r.address     = addr[AddrBits-1:0];
      r.write_word  = word;
      r.fault_kind  = fault;
      r.last_result = last;
      pending_results.push_back(r);
   endfunction

   function automatic void push_fault(logic [1:0] fault);
      push_result(KIND_FAULT, '0, '0, fault, 1'b1);
      walking    = 1'b0;
      root_level = 1'b1;
   endfunction

   function automatic void request_entry(logic [63:0] addr, logic at_root);
      if (addr > PhysLimit) begin
         push_fault(FAULT_ACCESS);
      end else begin
         entry_addr = addr;
         root_level = at_root;
         walking    = 1'b1;
         push_result(KIND_READ, addr, '0, FAULT_NONE, 1'b1);
      end
   endfunction

   function automatic void predict_walk(req_type t);
      logic [31:0] pte;
      logic [63:0] ppn;
      logic [63:0] vpn;
      logic [63:0] keep;
      logic [63:0] pa;
      logic [31:0] need;
      logic        permit;
      pte = t.entry_word;
      ppn = 64'(pte[31:10]);
      vpn = 64'(walk_va[31:12]);
      if (t.action == ACT_TRANSLATE) begin
         walking    = 1'b0;
         root_level = 1'b1;
         if (t.eff_priv == PRIV_MACHINE || !cfg.xlate_on) begin
            push_result(KIND_DONE, 64'(t.virt_addr), '0, FAULT_NONE, 1'b1);
         end else begin
            walk_va   = t.virt_addr;
            walk_kind = (t.access_kind == ACC_BAD) ? ACC_LOAD : t.access_kind;
            walk_priv = (t.eff_priv == PRIV_RSVD) ? PRIV_SUPER : t.eff_priv;
            request_entry((64'(cfg.root_page) << PageOffsetBits) +
                          64'(t.virt_addr[31:22]) * 4, 1'b1);
         end
      end else if (walking) begin
         if (!t.entry_read_allowed) begin
            push_fault(FAULT_ACCESS);
         end else if (!pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W])) begin
            push_fault(FAULT_PAGE);
         end else if (pte[PTE_R] || pte[PTE_X]) begin
            keep = root_level ? 64'h3ff : 64'h0;
            need = (32'd1 << PTE_A) | ((walk_kind == ACC_STORE) ? (32'd1 << PTE_D) : 32'd0);
            case (walk_kind)
               ACC_FETCH: permit = pte[PTE_X];
               ACC_STORE: permit = pte[PTE_W];
               default:   permit = pte[PTE_R] || (cfg.mxr && pte[PTE_X]);
            endcase
            if (permit) begin
               if (walk_priv == PRIV_USER)
                  permit = pte[PTE_U];
               else if (pte[PTE_U])
                  permit = (walk_kind != ACC_FETCH) && cfg.sum;
            end
            if ((ppn & keep) != 0 || !permit) begin
               push_fault(FAULT_PAGE);
            end else if ((pte & need) != need && !t.entry_write_allowed) begin
               push_fault(FAULT_ACCESS);
            end else begin
               if ((pte & need) != need)
                  push_result(KIND_WRITE, entry_addr, pte | need, FAULT_NONE, 1'b0);
               pa = (((ppn & ~keep) | (vpn & keep)) << PageOffsetBits) | 64'(walk_va[11:0]);
               if (pa > PhysLimit) begin
                  push_fault(FAULT_ACCESS);
               end else begin
                  push_result(KIND_DONE, pa, '0, FAULT_NONE, 1'b1);
                  walking    = 1'b0;
                  root_level = 1'b1;
               end
            end
         end else if (pte[PTE_A] || pte[PTE_D] || pte[PTE_U] || !root_level) begin
            push_fault(FAULT_PAGE);
         end else begin
            request_entry((ppn << PageOffsetBits) + 64'(vpn[9:0]) * 4, 1'b0);
         end
      end
   endfunction

   // result check and prediction, both at the rising edge
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      req_type seen;
      int      depth;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.result_kind = rsp_chan.result_kind;
            got.address     = rsp_chan.address;
            got.write_word  = rsp_chan.write_word;
            got.fault_kind  = rsp_chan.fault_kind;
            got.last_result = rsp_chan.last_result;
            if (pending_results.size() == 0) begin
               flag_mismatch({"unexpected result ", describe_result(got)});
            end else begin
               want = pending_results.pop_front();
               if (got.result_kind != want.result_kind || got.address != want.address ||
                   got.write_word != want.write_word || got.fault_kind != want.fault_kind ||
                   got.last_result != want.last_result)
                  flag_mismatch({"expected ", describe_result(want),
                                 " got ", describe_result(got)});
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.action              = req_chan.action;
            seen.virt_addr           = req_chan.virt_addr;
            seen.access_kind         = req_chan.access_kind;
            seen.eff_priv            = req_chan.eff_priv;
            seen.entry_word          = req_chan.entry_word;
            seen.entry_read_allowed  = req_chan.entry_read_allowed;
            seen.entry_write_allowed = req_chan.entry_write_allowed;
            depth = pending_results.size();
            predict_walk(seen);
            if (typed_on) begin
               while (pending_results.size() > depth)
                  void'(pending_results.pop_back());
               pending_results.push_back(typed_result);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MaxCycles) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic req_type random_item();
      req_type t;
      t.action              = 1'($urandom);
      t.virt_addr           = $urandom;
      t.access_kind         = 2'($urandom);
      t.eff_priv            = 2'($urandom);
      t.entry_word          = $urandom;
      t.entry_read_allowed  = 1'($urandom);
      t.entry_write_allowed = 1'($urandom);
      return t;
   endfunction

   function automatic req_type xlate(logic [31:0] va, logic [1:0] kind, logic [1:0] priv);
      req_type t;
      t             = random_item();
      t.action      = ACT_TRANSLATE;
      t.virt_addr   = va;
      t.access_kind = kind;
      t.eff_priv    = priv;
      return t;
   endfunction

   function automatic req_type entry(logic [31:0] word, logic rd_ok, logic wr_ok);
      req_type t;
      t                     = random_item();
      t.action              = ACT_RESPONSE;
      t.entry_word          = word;
      t.entry_read_allowed  = rd_ok;
      t.entry_write_allowed = wr_ok;
      return t;
   endfunction

   function automatic rsp_type done_rsp(logic [AddrBits-1:0] addr);
      rsp_type r;
      r             = '0;
      r.result_kind = KIND_DONE;
      r.address     = addr;
      r.fault_kind  = FAULT_NONE;
      r.last_result = 1'b1;
      return r;
   endfunction

   function automatic rsp_type fault_rsp(logic [1:0] fault);
      rsp_type r;
      r             = '0;
      r.result_kind = KIND_FAULT;
      r.fault_kind  = fault;
      r.last_result = 1'b1;
      return r;
   endfunction

   function automatic void add_step(logic set_cfg, cfg_type c, req_type t, logic typed,
                                    rsp_type r);
      step_row_type row;
      row.set_cfg = set_cfg;
      row.cfg     = c;
      row.item    = t;
      row.typed   = typed;
      row.result  = r;
      plan_q.push_back(row);
   endfunction

   function automatic logic [21:0] random_ppn();
      return ($urandom_range(0, 7) == 0) ? 22'($urandom) : {2'b00, 20'($urandom)};
   endfunction

   function automatic logic [31:0] make_leaf(logic mega, logic [1:0] kind, logic [1:0] priv);
      logic [31:0] w;
      logic [21:0] ppn;
      w   = $urandom;
      ppn = random_ppn();
      if (mega && $urandom_range(0, 9) != 0)
         ppn[9:0] = '0;
      w[31:10]  = ppn;
      w[PTE_V]  = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 4) != 0) begin
         w[PTE_X:PTE_R] = '0;
         case (kind)
            ACC_STORE: begin
               w[PTE_W] = 1'b1;
               w[PTE_R] = 1'b1;
            end
            ACC_FETCH: w[PTE_X] = 1'b1;
            default:   if ($urandom_range(0, 3) == 0) w[PTE_X] = 1'b1; else w[PTE_R] = 1'b1;
         endcase
         w[PTE_U] = (priv == PRIV_USER) ? 1'b1 : ($urandom_range(0, 3) == 0);
      end
      return w;
   endfunction

   function automatic logic [31:0] make_pointer();
      logic [31:0] w;
      w             = $urandom;
      w[31:10]      = random_ppn();
      w[PTE_X:PTE_V] = 4'b0001;
      if ($urandom_range(0, 9) != 0) begin
         w[PTE_A] = 1'b0;
         w[PTE_D] = 1'b0;
         w[PTE_U] = 1'b0;
      end
      if ($urandom_range(0, 29) == 0)
         w[PTE_V] = 1'b0;
      return w;
   endfunction

   task automatic send_item(req_type t, logic typed, rsp_type r);
      int gap;
      if (bursts_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      typed_on     = typed;
      typed_result = r;
      req_chan.valid               <= 1'b1;
      req_chan.action              <= t.action;
      req_chan.virt_addr           <= t.virt_addr;
      req_chan.access_kind         <= t.access_kind;
      req_chan.eff_priv            <= t.eff_priv;
      req_chan.entry_word          <= t.entry_word;
      req_chan.entry_read_allowed  <= t.entry_read_allowed;
      req_chan.entry_write_allowed <= t.entry_write_allowed;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stop sending and let every expected result come out
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic [1:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_config(cfg_type c);
      logic [31:0] vals[4];
      logic [31:0] rd;
      wait_drained();
      vals[REG_TRANSLATION_ON] = 32'(c.xlate_on);
      vals[REG_ROOT_PAGE]      = 32'(c.root_page);
      vals[REG_SUM]            = 32'(c.sum);
      vals[REG_MXR]            = 32'(c.mxr);
      for (int i = 0; i < 4; i++)
         csr_access(1'b1, 2'(i), vals[i], rd);
      cfg = c;
      for (int i = 0; i < 4; i++) begin
         csr_access(1'b0, 2'(i), '0, rd);
         if (rd != vals[i])
            flag_mismatch($sformatf("csr %0d expected %h got %h", i, vals[i], rd));
      end
   endtask

   task automatic random_walk(inout int count);
      req_type     t;
      logic [1:0]  priv;
      logic [1:0]  kind;
      int          sel;
      sel  = $urandom_range(0, 19);
      priv = (sel < 8) ? PRIV_USER : (sel < 16) ? PRIV_SUPER :
             (sel < 18) ? PRIV_RSVD : PRIV_MACHINE;
      t    = xlate($urandom, 2'($urandom_range(0, 3)), priv);
      kind = t.access_kind;
      send_item(t, 1'b0, '0);
      count++;
      if (priv == PRIV_MACHINE || !cfg.xlate_on)
         return;
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
         send_item(entry(make_leaf(1'b1, kind, priv), $urandom_range(0, 19) != 0,
                         $urandom_range(0, 9) != 0), 1'b0, '0);
         count++;
      end else if (sel < 9) begin
         send_item(entry(make_pointer(), $urandom_range(0, 29) != 0, 1'($urandom)), 1'b0, '0);
         send_item(entry(make_leaf(1'b0, kind, priv), $urandom_range(0, 19) != 0,
                         $urandom_range(0, 9) != 0), 1'b0, '0);
         count += 2;
      end
   endtask

   initial begin
      cfg_type c;
      cfg_type phase_cfg[6];
      int      phase_items[6];
      logic    phase_bursts[6];
      int      count;
      req_type n;

      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_chan.valid = 1'b0;
      req_chan.action              = ACT_TRANSLATE;
      req_chan.virt_addr           = '0;
      req_chan.access_kind         = ACC_LOAD;
      req_chan.eff_priv            = PRIV_USER;
      req_chan.entry_word          = '0;
      req_chan.entry_read_allowed  = 1'b0;
      req_chan.entry_write_allowed = 1'b0;
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
      bursts_on      = 1'b1;
      typed_on       = 1'b0;
      typed_result   = '0;
      mismatches     = 0;
      cycles         = 0;
      cfg            = '0;
      walking        = 1'b0;
      root_level     = 1'b1;
      walk_va        = '0;
      walk_kind      = ACC_LOAD;
      walk_priv      = PRIV_USER;
      entry_addr     = '0;

      // reset state: bare mode, everything passes through
      add_step(1'b0, '0, xlate(32'h0, ACC_LOAD, PRIV_USER), 1'b1, done_rsp(34'h0));
      add_step(1'b0, '0, xlate(32'hffffffff, ACC_FETCH, PRIV_SUPER), 1'b1,
               done_rsp(34'hffffffff));
      add_step(1'b0, '0, entry(32'hffffffff, 1'b1, 1'b1), 1'b0, '0);
      // root at the top of the page number range
      c = '{xlate_on: 1'b1, root_page: 22'h3fffff, sum: 1'b0, mxr: 1'b0};
      add_step(1'b1, c, xlate(32'hffffffff, ACC_STORE, PRIV_MACHINE), 1'b1,
               done_rsp(34'hffffffff));
      add_step(1'b0, '0, xlate(32'h12345678, ACC_LOAD, PRIV_SUPER), 1'b1,
               fault_rsp(FAULT_ACCESS));
      add_step(1'b0, '0, entry(32'h0, 1'b0, 1'b0), 1'b0, '0);
      // small root, SUM and MXR set
      c = '{xlate_on: 1'b1, root_page: 22'h000001, sum: 1'b1, mxr: 1'b1};
      add_step(1'b1, c, xlate(32'hffc00abc, ACC_STORE, PRIV_USER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h000000cf, 1'b0, 1'b1), 1'b1, fault_rsp(FAULT_ACCESS));
      add_step(1'b0, '0, xlate(32'h00400000, ACC_LOAD, PRIV_SUPER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000000, 1'b1, 1'b1), 1'b1, fault_rsp(FAULT_PAGE));
      add_step(1'b0, '0, xlate(32'h00400000, ACC_LOAD, PRIV_SUPER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000005, 1'b1, 1'b1), 1'b1, fault_rsp(FAULT_PAGE));
      add_step(1'b0, '0, xlate(32'h00400123, ACC_FETCH, PRIV_USER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000459, 1'b1, 1'b1), 1'b1, fault_rsp(FAULT_PAGE));
      add_step(1'b0, '0, xlate(32'h00400000, ACC_STORE, PRIV_SUPER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000841, 1'b1, 1'b1), 1'b1, fault_rsp(FAULT_PAGE));
      add_step(1'b0, '0, xlate(32'h00400000, ACC_BAD, PRIV_RSVD), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000801, 1'b1, 1'b1), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000c01, 1'b1, 1'b1), 1'b1, fault_rsp(FAULT_PAGE));
      add_step(1'b0, '0, xlate(32'h00801004, ACC_STORE, PRIV_USER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000801, 1'b1, 1'b1), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00000c17, 1'b1, 1'b0), 1'b1, fault_rsp(FAULT_ACCESS));
      add_step(1'b0, '0, xlate(32'hfffff000, ACC_STORE, PRIV_SUPER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'hfff0000f, 1'b1, 1'b1), 1'b0, '0);
      add_step(1'b0, '0, xlate(32'h00400abc, ACC_LOAD, PRIV_SUPER), 1'b0, '0);
      add_step(1'b0, '0, entry(32'h00100059, 1'b1, 1'b1), 1'b0, '0);
      add_step(1'b0, '0, xlate(32'h00400000, ACC_FETCH, PRIV_SUPER), 1'b0, '0);
      add_step(1'b0, '0, xlate(32'h00400000, ACC_LOAD, PRIV_USER), 1'b0, '0);

      phase_cfg[0] = '{xlate_on: 1'b1, root_page: 22'h000000, sum: 1'b0, mxr: 1'b0};
      phase_cfg[1] = '{xlate_on: 1'b1, root_page: 22'h3fffff, sum: 1'b1, mxr: 1'b1};
      phase_cfg[2] = '{xlate_on: 1'b1, root_page: 22'($urandom_range(0, 22'h0fffff)),
                       sum: 1'($urandom), mxr: 1'($urandom)};
      phase_cfg[3] = '{xlate_on: 1'b0, root_page: 22'h0fffff, sum: 1'b1, mxr: 1'b0};
      phase_cfg[4] = '{xlate_on: 1'b1, root_page: 22'h0fffff, sum: 1'b0, mxr: 1'b1};
      phase_cfg[5] = '{xlate_on: 1'b1, root_page: 22'($urandom_range(0, 22'h0fffff)),
                       sum: 1'($urandom), mxr: 1'($urandom)};
      phase_items  = '{250, 60, 250, 80, 250, 200};
      phase_bursts = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         if (plan_q[i].set_cfg)
            apply_config(plan_q[i].cfg);
         send_item(plan_q[i].item, plan_q[i].typed, plan_q[i].result);
      end

      for (int p = 0; p < 6; p++) begin
         apply_config(phase_cfg[p]);
         bursts_on = phase_bursts[p];
         count     = 0;
         while (count < phase_items[p]) begin
            if (count > 0 && $urandom_range(0, 9) == 0) begin
               n = random_item();
               send_item(n, 1'b0, '0);
               if (n.action == ACT_TRANSLATE)
                  count++;
            end else begin
               random_walk(count);
            end
            if ($urandom_range(0, 99) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
